>>> design/rcbt_pkg.sv
// Shared constants, codes and types of the reject-count block table.
package rcbt_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned RM_W    = 9;
  localparam int unsigned MODE_W  = 3;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;

  localparam int unsigned IN_W  = 72;
  localparam int unsigned OUT_W = 32;

  localparam logic [MODE_W-1:0] MODE_RECORD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXPIRE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  count;
    logic              blocked;
    logic [TIME_W-1:0] block_start;
    logic [TIME_W-1:0] last_reject;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic             start;   // request taken, latch it and clear scan state
    logic             scan;    // visit entry at ptr
    logic [IDX_W-1:0] ptr;
    logic             act;     // apply update and load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

>>> design/reject_count_ip_block_table_unit.sv
// Top level of the reject-count IPv4 block table.
// A request is handled in steps: the request is taken, every table entry is scanned in turn on
// the single entry read port, then a finish step writes the result once the output register is free.
// A new request is taken only after the previous one has finished; it is taken while the
// previous result still waits in the output register.
// Reset: asynchronous, active low; table empty, threshold and period zero, no result pending.
module reject_count_ip_block_table_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcbt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcbt_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] mode, [34:3] peer_address, [66:35] current_time, [71:67] zero
  input  logic [rcbt_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] found, [1] blocked, [17:2] reject_count, [18] dropped, [27:19] removed, [31:28] zero
  output logic [rcbt_pkg::OUT_W-1:0]     m_axis_tdata
);
  import rcbt_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic             in_valid;
  logic             found, blocked, dropped;
  logic [CNT_W-1:0] count;
  logic [RM_W-1:0]  removed;

  assign in_valid = s_axis_tvalid;

  rcbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcbt_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_mode_i     (s_axis_tdata[2:0]),
    .in_addr_i     (s_axis_tdata[34:3]),
    .in_time_i     (s_axis_tdata[66:35]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_found_o   (found),
    .out_blocked_o (blocked),
    .out_count_o   (count),
    .out_dropped_o (dropped),
    .out_removed_o (removed)
  );

  assign m_axis_tdata = {4'b0000, removed, dropped, count, blocked, found};

endmodule

>>> design/rcbt_ctrl.sv
// Sequencer: takes a request, walks all entries, then finishes the request.
module rcbt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rcbt_pkg::status_t status_i,
  output rcbt_pkg::cmd_t    cmd_o
);
  import rcbt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_ACT  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cmd_o     = '0;
    cmd_o.ptr = ptr_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          ptr_d       = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (ptr_q == IDX_W'(ENTRIES - 1)) begin
          state_d = ST_ACT;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_ACT: begin
        if (status_i.out_free) begin
          cmd_o.act = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

endmodule

>>> design/rcbt_datapath.sv
// Table storage, config registers, per-entry scan logic and result register.
module rcbt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcbt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcbt_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic [rcbt_pkg::MODE_W-1:0]   in_mode_i,
  input  logic [rcbt_pkg::ADDR_W-1:0]   in_addr_i,
  input  logic [rcbt_pkg::TIME_W-1:0]   in_time_i,
  input  rcbt_pkg::cmd_t                cmd_i,
  output rcbt_pkg::status_t             status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_found_o,
  output logic                          out_blocked_o,
  output logic [rcbt_pkg::CNT_W-1:0]    out_count_o,
  output logic                          out_dropped_o,
  output logic [rcbt_pkg::RM_W-1:0]     out_removed_o
);
  import rcbt_pkg::*;

  logic [THR_W-1:0]  thr_q;
  logic [TIME_W-1:0] period_q;

  logic [ENTRIES-1:0] valid_q;
  entry_t             tbl_q [ENTRIES];

  logic [MODE_W-1:0] mode_q;
  logic [ADDR_W-1:0] addr_q;
  logic [TIME_W-1:0] time_q;

  logic             match_q, free_q;
  logic [IDX_W-1:0] match_idx_q, free_idx_q;
  logic [RM_W-1:0]  rm_q;

  logic             ovalid_q;
  logic             found_q, blocked_q, dropped_q;
  logic [CNT_W-1:0] count_q;
  logic [RM_W-1:0]  removed_q;

  // single read port: scan pointer while walking, chosen slot afterwards
  logic [IDX_W-1:0] rd_idx, sel_idx;
  entry_t           rd;
  logic             rd_valid;

  assign sel_idx  = match_q ? match_idx_q : free_idx_q;
  assign rd_idx   = cmd_i.scan ? cmd_i.ptr : sel_idx;
  assign rd       = tbl_q[rd_idx];
  assign rd_valid = valid_q[rd_idx];

  // scan-side evaluation
  logic              s_match, s_eff_blk, s_expire, s_drop;
  logic [TIME_W-1:0] s_stamp, s_age;

  always_comb begin
    s_match   = rd_valid && (rd.address == addr_q);
    s_eff_blk = rd.blocked && (rd.count >= thr_q);
    s_stamp   = s_eff_blk ? rd.block_start : rd.last_reject;
    s_age     = time_q - s_stamp;
    s_expire  = s_age >= period_q;
    case (mode_q)
      MODE_EXPIRE: s_drop = rd_valid && s_expire;
      MODE_CLEAR:  s_drop = rd_valid;
      default:     s_drop = 1'b0;
    endcase
  end

  // finish-side evaluation
  logic [CNT_W-1:0] inc;
  logic             inc_hit;
  logic             wr_en, set_valid, clr_valid;
  entry_t           wr;
  logic             r_found, r_blk, r_drop;
  logic [CNT_W-1:0] r_cnt;
  logic [RM_W-1:0]  r_rm;

  always_comb begin
    inc       = (rd.count == CNT_MAX) ? rd.count : rd.count + 1'b1;
    inc_hit   = inc >= thr_q;
    wr_en     = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    wr        = rd;
    r_found   = 1'b0;
    r_blk     = 1'b0;
    r_drop    = 1'b0;
    r_cnt     = '0;
    r_rm      = '0;
    case (mode_q)
      MODE_RECORD: begin
        if (thr_q == '0) begin
          // recording disabled: report like a query, no update
          if (match_q) begin
            r_found = 1'b1;
            r_blk   = rd.blocked;
            r_cnt   = rd.count;
          end
        end else if (match_q) begin
          wr_en          = 1'b1;
          wr.count       = inc;
          wr.last_reject = time_q;
          if (inc_hit && !rd.blocked) begin
            wr.blocked     = 1'b1;
            wr.block_start = time_q;
          end
          r_found = 1'b1;
          r_blk   = inc_hit;
          r_cnt   = inc;
        end else if (free_q) begin
          wr_en          = 1'b1;
          set_valid      = 1'b1;
          wr.address     = addr_q;
          wr.count       = CNT_W'(1);
          wr.blocked     = (thr_q == THR_W'(1));
          wr.block_start = (thr_q == THR_W'(1)) ? time_q : '0;
          wr.last_reject = time_q;
          r_blk          = (thr_q == THR_W'(1));
          r_cnt          = CNT_W'(1);
        end else begin
          r_drop = 1'b1;
        end
      end
      MODE_QUERY: begin
        if (match_q) begin
          r_found = 1'b1;
          r_blk   = rd.blocked && (rd.count >= thr_q);
          r_cnt   = rd.count;
        end
      end
      MODE_DELETE: begin
        if (match_q) begin
          clr_valid = 1'b1;
          r_found   = 1'b1;
          r_rm      = RM_W'(1);
        end
      end
      MODE_EXPIRE, MODE_CLEAR: r_rm = rm_q;
      default: ;
    endcase
  end

  // config, valid bits and scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      period_q    <= '0;
      valid_q     <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      match_idx_q <= '0;
      free_idx_q  <= '0;
      rm_q        <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_THRESHOLD: begin
            thr_q <= cfg_wdata_i[THR_W-1:0];
            if (cfg_wdata_i[THR_W-1:0] == '0) valid_q <= '0;
          end
          CFG_PERIOD: period_q <= cfg_wdata_i[TIME_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        match_q <= 1'b0;
        free_q  <= 1'b0;
        rm_q    <= '0;
      end
      if (cmd_i.scan) begin
        if (!match_q && s_match) begin
          match_q     <= 1'b1;
          match_idx_q <= cmd_i.ptr;
        end
        if (!free_q && !rd_valid) begin
          free_q     <= 1'b1;
          free_idx_q <= cmd_i.ptr;
        end
        if (s_drop) begin
          valid_q[cmd_i.ptr] <= 1'b0;
          rm_q               <= rm_q + 1'b1;
        end
      end
      if (cmd_i.act) begin
        if (set_valid) valid_q[sel_idx] <= 1'b1;
        if (clr_valid) valid_q[sel_idx] <= 1'b0;
      end
      if (cmd_i.act) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= in_mode_i;
      addr_q <= in_addr_i;
      time_q <= in_time_i;
    end
    if (cmd_i.act && wr_en) begin
      tbl_q[sel_idx] <= wr;
    end
    if (cmd_i.act) begin
      found_q   <= r_found;
      blocked_q <= r_blk;
      count_q   <= r_cnt;
      dropped_q <= r_drop;
      removed_q <= r_rm;
    end
  end

  assign status_o.out_free = !ovalid_q || out_ready_i;

  assign out_valid_o   = ovalid_q;
  assign out_found_o   = found_q;
  assign out_blocked_o = blocked_q;
  assign out_count_o   = count_q;
  assign out_dropped_o = dropped_q;
  assign out_removed_o = removed_q;

endmodule
